>>> hw/rtl/prb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_pkg
// shared types and codes of the palette rectangle blitter
// ----------------------------------------------------------------------------
package prb_pkg;

  typedef enum logic [2:0] {
    FUNC_WR_TEXEL = 3'd0,
    FUNC_WR_PAL   = 3'd1,
    FUNC_DRAW     = 3'd2,
    FUNC_CLEAR    = 3'd3,
    FUNC_READ     = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_TRANS = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_FB_W  = 3'd0,
    CFG_FB_H  = 3'd1,
    CFG_TEX_W = 3'd2,
    CFG_TEX_H = 3'd3,
    CFG_COLOR = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TCLR,
    ST_SETUP,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item, compute bounds
    logic tclr;      // texture clearing step
    logic walk;      // one pixel step of draw or clear
    logic rd_req;    // compute row bases of the first row
    logic finish;    // form result, write texel or palette
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tclr_done;
    logic walk_last;
    logic walk_empty;
    logic pipe_busy;
  } stat_t;

  localparam logic [7:0] ALPHA_FULL = 8'd255;

endpackage

>>> hw/rtl/prb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_ctrl
// sequencer: texture clear after reset, item setup, pixel walk or read, result
// ----------------------------------------------------------------------------
module prb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     func_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  prb_pkg::stat_t stat_i,
  output prb_pkg::cmd_t  cmd_o
);

  prb_pkg::state_e state_q, state_d;
  logic [2:0] func_q;
  logic out_valid_q, out_valid_d;
  logic done_ok;

  // result register free and walk pipeline drained
  assign done_ok = !out_valid_q && !stat_i.pipe_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prb_pkg::ST_TCLR;
      out_valid_q <= 1'b0;
      func_q      <= 3'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_valid_i && in_ready_o) func_q <= func_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      prb_pkg::ST_TCLR:  if (stat_i.tclr_done) state_d = prb_pkg::ST_IDLE;
      prb_pkg::ST_IDLE:  if (in_valid_i) state_d = prb_pkg::ST_SETUP;
      prb_pkg::ST_SETUP: begin
        if ((func_q == prb_pkg::FUNC_DRAW || func_q == prb_pkg::FUNC_CLEAR) &&
            !stat_i.walk_empty) begin
          state_d = prb_pkg::ST_WALK;
        end else if (func_q == prb_pkg::FUNC_READ) begin
          state_d = prb_pkg::ST_READ;
        end else begin
          state_d = prb_pkg::ST_DONE;
        end
      end
      prb_pkg::ST_WALK:  if (stat_i.walk_last) state_d = prb_pkg::ST_DONE;
      prb_pkg::ST_READ:  state_d = prb_pkg::ST_DONE;
      prb_pkg::ST_DONE:  if (done_ok) state_d = prb_pkg::ST_IDLE;
      default:           state_d = prb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == prb_pkg::ST_DONE && done_ok) out_valid_d = 1'b1;
  end

  always_comb begin
    cmd_o        = '0;
    in_ready_o   = (state_q == prb_pkg::ST_IDLE);
    cmd_o.load   = (state_q == prb_pkg::ST_IDLE) && in_valid_i;
    cmd_o.tclr   = (state_q == prb_pkg::ST_TCLR);
    cmd_o.walk   = (state_q == prb_pkg::ST_WALK);
    cmd_o.rd_req = (state_q == prb_pkg::ST_SETUP);
    cmd_o.finish = (state_q == prb_pkg::ST_DONE) && done_ok;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/prb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_dp
// datapath: stores, clip bounds, walk counters, address and paint logic
// ----------------------------------------------------------------------------
module prb_dp #(
  parameter int FB_MAX_W  = 1024,
  parameter int FB_MAX_H  = 512,
  parameter int TEX_MAX_W = 2048,
  parameter int TEX_MAX_H = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [11:0]    cfg_data_i,
  input  logic [2:0]     func_i,
  input  logic [1:0]     mode_i,
  input  logic [11:0]    dest_x_i,
  input  logic [11:0]    dest_y_i,
  input  logic [11:0]    rect_w_i,
  input  logic [11:0]    rect_h_i,
  input  logic [11:0]    src_x_i,
  input  logic [11:0]    src_y_i,
  input  logic [7:0]     index_value_i,
  input  logic [23:0]    rgb_value_i,
  input  prb_pkg::cmd_t  cmd_i,
  output prb_pkg::stat_t stat_o,
  output logic [31:0]    pixel_rgba_o
);

  localparam int FbDepth  = FB_MAX_W * FB_MAX_H;
  localparam int TexDepth = TEX_MAX_W * TEX_MAX_H;
  localparam int FbAw     = (FbDepth > 1) ? $clog2(FbDepth) : 1;
  localparam int TexAw    = (TexDepth > 1) ? $clog2(TexDepth) : 1;
  localparam int TcW      = TexAw + 1;

  // signed coordinates, 14 bit covers all sums
  typedef logic signed [13:0] crd_t;

  logic [23:0] frame_mem [FbDepth];
  logic [7:0]  tex_mem   [TexDepth];
  logic [23:0] pal_mem   [256];

  logic [10:0] fb_w_q;
  logic [9:0]  fb_h_q;
  logic [11:0] tex_w_q;
  logic [6:0]  tex_h_q;
  logic [7:0]  color_q;

  logic [TcW-1:0] tclr_q;

  logic [2:0]  func_q;
  logic [1:0]  mode_q;
  crd_t        dx_q, dy_q, sx_q, sy_q;
  crd_t        x0_q, x1_q, y1_q;
  crd_t        x_q, y_q;
  logic        empty_q;
  logic [7:0]  ival_q;
  logic [23:0] rgb_q;
  logic [31:0] pix_q;
  logic        in_fb_q;
  logic [23:0] rd_q;
  // row base offsets, kept incrementally (no multiply per pixel)
  logic [FbAw:0]  fb_row_q;
  logic [TexAw:0] tex_row_q;

  crd_t fw, fh, tw, th;
  assign fw = (crd_t'(fb_w_q) > crd_t'(FB_MAX_W)) ? crd_t'(FB_MAX_W) : crd_t'(fb_w_q);
  assign fh = (crd_t'(fb_h_q) > crd_t'(FB_MAX_H)) ? crd_t'(FB_MAX_H) : crd_t'(fb_h_q);
  assign tw = (crd_t'(tex_w_q) > crd_t'(TEX_MAX_W)) ? crd_t'(TEX_MAX_W)
                                                     : crd_t'(tex_w_q);
  assign th = (crd_t'(tex_h_q) > crd_t'(TEX_MAX_H)) ? crd_t'(TEX_MAX_H)
                                                     : crd_t'(tex_h_q);

  function automatic crd_t mx(crd_t a, crd_t b);
    return (a > b) ? a : b;
  endfunction
  function automatic crd_t mn(crd_t a, crd_t b);
    return (a < b) ? a : b;
  endfunction

  crd_t in_dx, in_dy, in_sx, in_sy, bx0, bx1, by0, by1;
  always_comb begin
    in_dx = crd_t'($signed(dest_x_i));
    in_dy = crd_t'($signed(dest_y_i));
    in_sx = crd_t'($signed(src_x_i));
    in_sy = crd_t'($signed(src_y_i));
    if (func_i == prb_pkg::FUNC_CLEAR) begin
      bx0 = '0; bx1 = fw; by0 = '0; by1 = fh;
    end else begin
      bx0 = mx(mx(14'sd0, -in_dx), -in_sx);
      bx1 = mn(mn(crd_t'({2'b00, rect_w_i}), fw - in_dx), tw - in_sx);
      by0 = mx(mx(14'sd0, -in_dy), -in_sy);
      by1 = mn(mn(crd_t'({2'b00, rect_h_i}), fh - in_dy), th - in_sy);
    end
  end

  // walk start only matters for draw and clear; others address from the item
  logic walk_item;
  assign walk_item = (func_i == prb_pkg::FUNC_DRAW) || (func_i == prb_pkg::FUNC_CLEAR);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_w_q  <= 11'd1024;
      fb_h_q  <= 10'd512;
      tex_w_q <= 12'd2048;
      tex_h_q <= 7'd64;
      color_q <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        prb_pkg::CFG_FB_W:  fb_w_q  <= cfg_data_i[10:0];
        prb_pkg::CFG_FB_H:  fb_h_q  <= cfg_data_i[9:0];
        prb_pkg::CFG_TEX_W: tex_w_q <= cfg_data_i;
        prb_pkg::CFG_TEX_H: tex_h_q <= cfg_data_i[6:0];
        prb_pkg::CFG_COLOR: color_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tclr_q <= '0;
    else if (cmd_i.tclr) tclr_q <= tclr_q + TcW'(1);
  end
  assign stat_o.tclr_done = (tclr_q == TcW'(TexDepth - 1));

  // walk state
  logic x_last, y_last;
  assign x_last = (x_q + 14'sd1 >= x1_q);
  assign y_last = (y_q + 14'sd1 >= y1_q);
  assign stat_o.walk_last  = x_last && y_last;
  assign stat_o.walk_empty = empty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      mode_q  <= mode_i;
      dx_q    <= (func_i == prb_pkg::FUNC_CLEAR) ? '0 : in_dx;
      dy_q    <= (func_i == prb_pkg::FUNC_CLEAR) ? '0 : in_dy;
      sx_q    <= in_sx;
      sy_q    <= in_sy;
      x0_q    <= bx0;
      x1_q    <= bx1;
      y1_q    <= by1;
      x_q     <= walk_item ? bx0 : '0;
      y_q     <= walk_item ? by0 : '0;
      empty_q <= (bx0 >= bx1) || (by0 >= by1) ||
                 (func_i == prb_pkg::FUNC_DRAW && mode_i == prb_pkg::MODE_NONE);
      ival_q  <= index_value_i;
      rgb_q   <= rgb_value_i;
      in_fb_q <= (in_dx >= 0) && (in_dy >= 0) && (in_dx < fw) && (in_dy < fh);
    end else if (cmd_i.rd_req) begin
      // row bases of first row, one multiply each, registered
      fb_row_q  <= (FbAw+1)'((func_q == prb_pkg::FUNC_READ ? dy_q : dy_q + y_q) * fw);
      tex_row_q <= (TexAw+1)'((sy_q + y_q) * tw);
    end else if (cmd_i.walk) begin
      if (x_last) begin
        x_q       <= x0_q;
        y_q       <= y_q + 14'sd1;
        fb_row_q  <= fb_row_q + (FbAw+1)'(fw);
        tex_row_q <= tex_row_q + (TexAw+1)'(tw);
      end else begin
        x_q <= x_q + 14'sd1;
      end
    end
  end

  // texel and frame addresses
  logic [FbAw:0]  fb_addr;
  logic [TexAw:0] tex_addr;
  assign fb_addr  = fb_row_q + (FbAw+1)'(dx_q + x_q);
  assign tex_addr = tex_row_q + (TexAw+1)'(sx_q + x_q);

  // walk pipeline: texel read, palette read, frame write
  logic            s1_vld_q, s2_vld_q, s2_paint_q;
  logic [FbAw-1:0] s1_addr_q, s2_addr_q;
  logic [7:0]      s1_texel_q;
  logic [23:0]     s2_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.walk;
      s2_vld_q <= s1_vld_q;
    end
  end
  assign stat_o.pipe_busy = s1_vld_q || s2_vld_q;

  logic [7:0]  texel;
  logic [7:0]  pal_idx;
  logic        paint;
  assign texel = (func_q == prb_pkg::FUNC_CLEAR) ? 8'd0 : s1_texel_q;
  always_comb begin
    pal_idx = 8'd0;
    paint   = 1'b1;
    if (func_q == prb_pkg::FUNC_DRAW) begin
      case (mode_q)
        prb_pkg::MODE_COPY:  pal_idx = texel;
        prb_pkg::MODE_COLOR: pal_idx = (texel != 8'd0) ? color_q : 8'd0;
        prb_pkg::MODE_TRANS: begin
          pal_idx = color_q;
          paint   = (texel != 8'd0);
        end
        default: paint = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    s1_texel_q <= tex_mem[tex_addr[TexAw-1:0]];
    s1_addr_q  <= fb_addr[FbAw-1:0];
    s2_addr_q  <= s1_addr_q;
    s2_paint_q <= paint;
    s2_rgb_q   <= pal_mem[pal_idx];
  end

  logic [TexAw-1:0] twr_addr;
  logic             twr_ok;
  assign twr_ok = (sx_q >= 0) && (sy_q >= 0) && (sx_q < tw) && (sy_q < th);
  assign twr_addr = TexAw'(tex_row_q + (TexAw+1)'(sx_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.tclr) tex_mem[tclr_q[TexAw-1:0]] <= 8'd0;
    else if (cmd_i.finish && func_q == prb_pkg::FUNC_WR_TEXEL && twr_ok)
      tex_mem[twr_addr] <= ival_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && func_q == prb_pkg::FUNC_WR_PAL) pal_mem[ival_q] <= rgb_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_paint_q) frame_mem[s2_addr_q] <= s2_rgb_q;
  end

  // read pixel: address valid in READ state
  always_ff @(posedge clk_i) begin
    rd_q <= frame_mem[fb_addr[FbAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pix_q <= '0;
    else if (cmd_i.finish) begin
      pix_q <= (func_q == prb_pkg::FUNC_READ && in_fb_q) ?
               {prb_pkg::ALPHA_FULL, rd_q} : 32'd0;
    end
  end
  assign pixel_rgba_o = pix_q;

endmodule

>>> hw/rtl/palette_rect_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rect_blitter
// palettized rectangle blitter with clipping, palette and frame store
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | func..rgb_value
// out     | output    | out_valid_o/out_ready_i | pixel_rgba_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// after reset the texture is zeroed one texel a cycle, no item taken
// meanwhile. an item passes the setup and done states; a draw or clear
// that walks pixels walks one pixel per cycle between them (clear:
// fb_width*fb_height), set by the single frame write port.
// a read pixel passes setup, read and done. a waiting result lets one more
// item in, which then holds before its result until the waiting one is taken.
module palette_rect_blitter #(
  parameter int FB_MAX_W  = 1024,
  parameter int FB_MAX_H  = 512,
  parameter int TEX_MAX_W = 2048,
  parameter int TEX_MAX_H = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [1:0]  mode_i,
  input  logic [11:0] dest_x_i,
  input  logic [11:0] dest_y_i,
  input  logic [11:0] rect_w_i,
  input  logic [11:0] rect_h_i,
  input  logic [11:0] src_x_i,
  input  logic [11:0] src_y_i,
  input  logic [7:0]  index_value_i,
  input  logic [23:0] rgb_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_rgba_o
);

  prb_pkg::cmd_t  cmd;
  prb_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  prb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .out_valid_o, .out_ready_i, .stat_i(stat), .cmd_o(cmd)
  );

  prb_dp #(
    .FB_MAX_W(FB_MAX_W), .FB_MAX_H(FB_MAX_H),
    .TEX_MAX_W(TEX_MAX_W), .TEX_MAX_H(TEX_MAX_H)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .func_i, .mode_i, .dest_x_i, .dest_y_i, .rect_w_i, .rect_h_i,
    .src_x_i, .src_y_i, .index_value_i, .rgb_value_i,
    .cmd_i(cmd), .stat_o(stat), .pixel_rgba_o
  );

endmodule

>>> hw/rtl/prb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prb_checker
// port level checks of the blitter
// ----------------------------------------------------------------------------
module prb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pixel_rgba_o
);

  // an accepted item keeps the input closed in the cycle after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("item taken while busy");

  // result held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_rgba_o))
    else $error("result dropped");

  // a valid result has alpha full or is zero
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_rgba_o[31:24] == 8'hFF || pixel_rgba_o == 32'd0)
    else $error("bad alpha");

endmodule

bind palette_rect_blitter prb_checker u_prb_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
  .out_valid_o, .out_ready_i, .pixel_rgba_o
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the palette rectangle blitter
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own copy of texture, palette, frame store and
// size registers. it predicts the pixel word of every accepted item and
// compares it with the result stream in order. the stimulus runs through
// several size settings, the extreme and the empty ones among them. it starts
// with a directed set of items, then sends random ones. both channels idle in
// random bursts, and the result side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  localparam int FBW = 1024, FBH = 512, TXW = 2048, TXH = 64;
  localparam int IDLE_LIMIT = 600000;

  typedef struct {
    logic [2:0]  func;
    logic [1:0]  mode;
    logic [11:0] dx, dy, rw, rh, sx, sy;
    logic [7:0]  ival;
    logic [23:0] rgb;
  } blit_item_t;

  class blit_scoreboard;
    logic [23:0] frame[];
    bit          fwritten[];
    logic [7:0]  tex[];
    logic [23:0] pal[256];
    int          fbw_r, fbh_r, texw_r, texh_r;
    logic [7:0]  color_r;
    logic [31:0] pending[$];
    int          errors;

    function new();
      frame = new[FBW * FBH];
      fwritten = new[FBW * FBH];
      tex = new[TXW * TXH];
      foreach (tex[i]) tex[i] = 8'd0;
      fbw_r = 1024; fbh_r = 512; texw_r = 2048; texh_r = 64; color_r = 8'd0;
      errors = 0;
    endfunction

    function int fw(); return fbw_r > FBW ? FBW : fbw_r; endfunction
    function int fh(); return fbh_r > FBH ? FBH : fbh_r; endfunction
    function int tw(); return texw_r > TXW ? TXW : texw_r; endfunction
    function int th(); return texh_r > TXH ? TXH : texh_r; endfunction

    function void set_reg(prb_pkg::cfg_idx_e idx, logic [11:0] v);
      case (idx)
        prb_pkg::CFG_FB_W:  fbw_r = v[10:0];
        prb_pkg::CFG_FB_H:  fbh_r = v[9:0];
        prb_pkg::CFG_TEX_W: texw_r = v;
        prb_pkg::CFG_TEX_H: texh_r = v[6:0];
        prb_pkg::CFG_COLOR: color_r = v[7:0];
        default: ;
      endcase
    endfunction

    // a read inside the frame must hit a pixel already painted
    function bit readable(int x, int y);
      if (x < 0 || y < 0 || x >= fw() || y >= fh()) return 1;
      return fwritten[y * fw() + x];
    endfunction

    function void paint(int idx, logic [7:0] p);
      frame[idx] = pal[p];
      fwritten[idx] = 1;
    endfunction

    function void note_item(blit_item_t it);
      int dx, dy, sx, sy, rw, rh, x0, x1, y0, y1, x, y, idx;
      logic [7:0] t;
      logic [31:0] res;
      dx = int'($signed(it.dx)); dy = int'($signed(it.dy));
      sx = int'($signed(it.sx)); sy = int'($signed(it.sy));
      rw = int'(it.rw); rh = int'(it.rh);
      res = 32'd0;
      case (it.func)
        prb_pkg::FUNC_WR_TEXEL:
          if (sx >= 0 && sy >= 0 && sx < tw() && sy < th()) tex[sy * tw() + sx] = it.ival;
        prb_pkg::FUNC_WR_PAL: pal[it.ival] = it.rgb;
        prb_pkg::FUNC_DRAW: if (it.mode != prb_pkg::MODE_NONE) begin
          x0 = 0; if (-dx > x0) x0 = -dx; if (-sx > x0) x0 = -sx;
          x1 = rw; if (fw() - dx < x1) x1 = fw() - dx; if (tw() - sx < x1) x1 = tw() - sx;
          y0 = 0; if (-dy > y0) y0 = -dy; if (-sy > y0) y0 = -sy;
          y1 = rh; if (fh() - dy < y1) y1 = fh() - dy; if (th() - sy < y1) y1 = th() - sy;
          for (y = y0; y < y1; y++)
            for (x = x0; x < x1; x++) begin
              idx = (dy + y) * fw() + dx + x;
              t = tex[(sy + y) * tw() + sx + x];
              if (it.mode == prb_pkg::MODE_COPY) paint(idx, t);
              else if (it.mode == prb_pkg::MODE_COLOR) paint(idx, t != 0 ? color_r : 8'd0);
              else if (t != 0) paint(idx, color_r);
            end
        end
        prb_pkg::FUNC_CLEAR: for (idx = 0; idx < fw() * fh(); idx++) paint(idx, 8'd0);
        prb_pkg::FUNC_READ:
          if (dx >= 0 && dy >= 0 && dx < fw() && dy < fh())
            res = {prb_pkg::ALPHA_FULL, frame[dy * fw() + dx]};
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch: %s expected %h got %h", what, want, got);
      errors++;
    endtask

    task check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        report("unexpected result", 32'd0, got);
        return;
      end
      want = pending.pop_front();
      if (want !== got) report("pixel_rgba", want, got);
    endtask
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_valid_i = 0, cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 0, in_ready_o;
  logic [2:0]  func_i = '0;
  logic [1:0]  mode_i = '0;
  logic [11:0] dest_x_i = '0, dest_y_i = '0, rect_w_i = '0, rect_h_i = '0;
  logic [11:0] src_x_i = '0, src_y_i = '0;
  logic [7:0]  index_value_i = '0;
  logic [23:0] rgb_value_i = '0;
  logic        out_valid_o, out_ready_i = 0;
  logic [31:0] pixel_rgba_o;

  blit_scoreboard sb = new();
  bit no_idle = 0, hold_req = 0;
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  palette_rect_blitter dut (.*);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_pixel(pixel_rgba_o);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 0;
        repeat (400) @(negedge clk_i);
      end else if (!no_idle && $urandom_range(3) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(7)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1;
        repeat ($urandom_range(15)) @(negedge clk_i);
      end
    end
  end

  task automatic send(blit_item_t it);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
    func_i <= it.func; mode_i <= it.mode;
    dest_x_i <= it.dx; dest_y_i <= it.dy; rect_w_i <= it.rw; rect_h_i <= it.rh;
    src_x_i <= it.sx; src_y_i <= it.sy; index_value_i <= it.ival; rgb_value_i <= it.rgb;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_sizes(int fbw, int fbh, int texw, int texh, int color);
    logic [11:0] vals[5];
    vals = '{12'(fbw), 12'(fbh), 12'(texw), 12'(texh), 12'(color)};
    drain();
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_index_i <= prb_pkg::cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      cfg_valid_i <= 1;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(prb_pkg::cfg_idx_e'(i), vals[i]);
    end
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic blit_item_t mk(logic [2:0] f, logic [1:0] m, int dx, int dy, int w,
                                    int h, int sx, int sy, int iv, int rgb);
    blit_item_t it;
    it.func = f; it.mode = m; it.dx = 12'(dx); it.dy = 12'(dy);
    it.rw = 12'(w); it.rh = 12'(h);
    it.sx = 12'(sx); it.sy = 12'(sy); it.ival = 8'(iv); it.rgb = 24'(rgb);
    return it;
  endfunction

  // coordinate near the span [0, n), now and then anywhere in 12 bits
  function automatic int near(int n);
    if ($urandom_range(19) == 0) return int'($signed(12'($urandom)));
    return $urandom_range(n + 4) - 4;
  endfunction

  function automatic blit_item_t rand_item();
    blit_item_t it;
    int pick, x, y;
    it = mk(prb_pkg::FUNC_READ, 2'($urandom), 0, 0, 0, 0, 0, 0, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.func = prb_pkg::FUNC_WR_TEXEL;
      it.sx = 12'(near(sb.tw())); it.sy = 12'(near(sb.th()));
      if ($urandom_range(2) == 0) it.ival = 8'd0;
    end else if (pick < 33) begin
      it.func = prb_pkg::FUNC_WR_PAL;
    end else if (pick < 68) begin
      it.func = prb_pkg::FUNC_DRAW;
      it.dx = 12'(near(sb.fw())); it.dy = 12'(near(sb.fh()));
      it.sx = 12'(near(sb.tw())); it.sy = 12'(near(sb.th()));
      it.rw = 12'($urandom_range(12)); it.rh = 12'($urandom_range(12));
      if ($urandom_range(30) == 0) begin
        it.rw = 12'($urandom); it.rh = 12'($urandom);
      end
    end else if (pick < 70 && sb.fw() * sb.fh() <= 4096) begin
      it.func = prb_pkg::FUNC_CLEAR;
    end else if (pick < 97) begin
      x = near(sb.fw()); y = near(sb.fh());
      if (!sb.readable(x, y)) x = -1 - $urandom_range(5);
      it.dx = 12'(x); it.dy = 12'(y);
    end else begin
      it.func = 3'($urandom_range(7, 5));
      it.dx = 12'($urandom); it.sx = 12'($urandom); it.rw = 12'($urandom);
    end
    return it;
  endfunction

  task automatic run_phase(int fbw, int fbh, int texw, int texh, int color, int n);
    set_sizes(fbw, fbh, texw, texh, color);
    send(mk(prb_pkg::FUNC_CLEAR, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < n; i++) begin
      if (i == 40 && fbw == 32) hold_req = 1;
      send(rand_item());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    set_sizes(32, 16, 64, 16, 5);
    for (int p = 0; p < 256; p++)
      send(mk(prb_pkg::FUNC_WR_PAL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, p, $urandom));
    send(mk(prb_pkg::FUNC_CLEAR, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 0, 0));
    // directed: bounds of texture and frame, each mode, unused codes
    send(mk(prb_pkg::FUNC_WR_TEXEL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 255, 0));
    send(mk(prb_pkg::FUNC_WR_TEXEL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 63, 15, 1, 0));
    send(mk(prb_pkg::FUNC_WR_TEXEL, prb_pkg::MODE_COPY, 0, 0, 0, 0, -1, 0, 9, 0));
    send(mk(prb_pkg::FUNC_WR_TEXEL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 64, 0, 9, 0));
    send(mk(prb_pkg::FUNC_WR_TEXEL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 16, 9, 0));
    send(mk(prb_pkg::FUNC_WR_TEXEL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 2047, -2048, 9, 0));
    send(mk(prb_pkg::FUNC_DRAW, prb_pkg::MODE_COPY, 0, 0, 64, 16, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_DRAW, prb_pkg::MODE_COLOR, -2048, 3, 4095, 4095, 2, -1, 0, 0));
    send(mk(prb_pkg::FUNC_DRAW, prb_pkg::MODE_TRANS, -5, -3, 4095, 4095, 40, 0, 0, 0));
    send(mk(prb_pkg::FUNC_DRAW, prb_pkg::MODE_NONE, 0, 0, 10, 10, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_DRAW, prb_pkg::MODE_COPY, 3, 3, 0, 5, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_DRAW, prb_pkg::MODE_COPY, 30, 14, 2048, 2048, 62, 14, 0, 0));
    send(mk(prb_pkg::FUNC_READ, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_READ, prb_pkg::MODE_COPY, 31, 15, 0, 0, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_READ, prb_pkg::MODE_COPY, -1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_READ, prb_pkg::MODE_COPY, 32, 0, 0, 0, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_READ, prb_pkg::MODE_COPY, 0, 16, 0, 0, 0, 0, 0, 0));
    send(mk(prb_pkg::FUNC_READ, prb_pkg::MODE_COPY, 2047, 2047, 0, 0, 0, 0, 0, 0));
    for (int f = 5; f < 8; f++)
      send(mk(3'(f), prb_pkg::MODE_NONE, -1, -1, 4095, 4095, -1, -1, 255, 24'hffffff));
    send(mk(prb_pkg::FUNC_WR_PAL, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 255, 24'hffffff));
    send(mk(prb_pkg::FUNC_CLEAR, prb_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 0, 0));
    run_phase(32, 16, 64, 16, 5, 210);
    run_phase(2047, 4, 4095, 127, 255, 210);
    run_phase(1, 1023, 1, 1, 0, 200);
    run_phase(0, 16, 0, 64, 128, 200);
    run_phase(1024, 0, 2048, 0, 77, 200);
    no_idle = 1;
    run_phase(48, 24, 100, 40, 200, 210);
    drain();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
